FILE: hw/rtl/cpsg_pkg.sv
// ----------------------------------------------------------------------------
// cpsg_pkg
// shared codes and types for the circle point and span generator
// ----------------------------------------------------------------------------
package cpsg_pkg;

    localparam int SEQ_W = 3;

    // request kind on the input stream tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // index of the final result of one step
    localparam logic [SEQ_W-1:0] OUTLINE_LAST = 3'd7;
    localparam logic [SEQ_W-1:0] FILL_LAST    = 3'd3;

    typedef struct packed {
        logic             fill;
        logic [SEQ_W-1:0] idx;
    } t_span_sel;

endpackage

FILE: hw/rtl/circle_point_span_generator.sv
// ----------------------------------------------------------------------------
// circle_point_span_generator
// integer decision variable circle rasterizer, points or filled spans
// ----------------------------------------------------------------------------
// input stream: tuser selects start (load center, radius, mode) or step.
// a start request loads the circle and gives no output.
// a step request runs one iteration: the decision update is applied when
// the request is taken and the iteration's offsets are latched into the
// emitter, which sends eight points (outline) or four spans (fill), one
// per cycle while the receiver takes them, through the output register.
// tlast marks the final result of a step, tuser marks the final result
// of the circle. the first result of a step passes through the emitter
// and then the output register. steps are paced by the single output
// port of the emitter; the next request is taken in the cycle the last
// result of the previous step enters the output register. a step while
// no circle is running is taken and gives nothing.
// when the receiver stalls the output register and emitter hold, and
// tready drops once the emitter has a step in flight.
// reset: no circle running, outline mode, circle offsets and center cleared.
// ----------------------------------------------------------------------------
module circle_point_span_generator
    import cpsg_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // center_x, center_y, radius, fill_mode
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]             s_axis_tdata,
    // action
    input  logic                                          s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // span_x_start, span_x_end, span_y
    output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0]         m_axis_tdata,
    output logic                                          m_axis_tlast,
    // circle_done
    output logic                                          m_axis_tuser
);

    localparam int CW    = COORD_BITS;
    localparam int EW    = COORD_BITS + 1;
    localparam int DW    = COORD_BITS + 2;
    localparam int XW    = DW + 2;
    localparam int OUT_W = ((3*EW+7)/8)*8;

    localparam logic signed [CW-1:0] ONE_C = 1;
    localparam logic signed [DW-1:0] ONE_D = 1;
    localparam logic signed [XW-1:0] ONE_X = 1;

    // circle state
    logic signed [CW-1:0] r_cx, r_cy, r_a, r_b;
    logic        [CW-2:0] r_rad;
    logic signed [DW-1:0] r_d;
    logic                 r_active, r_fill;
    logic signed [CW-1:0] n_cx, n_cy, n_a, n_b;
    logic        [CW-2:0] n_rad;
    logic signed [DW-1:0] n_d;
    logic                 n_active, n_fill;

    // emitter
    logic                 r_busy, r_e_fill, r_e_done;
    logic [SEQ_W-1:0]     r_idx;
    logic signed [CW-1:0] r_e_cx, r_e_cy, r_e_a, r_e_b;

    // output register
    logic                 r_m_valid, r_m_last, r_m_done;
    logic [OUT_W-1:0]     r_m_data;

    logic                 in_acc, step_run, out_load, emit_last;
    logic signed [EW-1:0] w_xs, w_xe, w_y;
    logic                 w_last;
    logic signed [XW-1:0] w_d, w_a, w_b, w_r;
    logic signed [CW-1:0] upd_a, upd_b;
    logic signed [DW-1:0] upd_d;
    logic                 upd_done;
    t_span_sel            w_sel;

    assign out_load      = !r_m_valid || m_axis_tready;
    assign emit_last     = r_busy && w_last;
    assign s_axis_tready = !r_busy || (emit_last && out_load);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign step_run      = in_acc && (s_axis_tuser == ACT_STEP) && r_active;

    // three-way decision update
    always_comb begin
        w_d = XW'(r_d);
        w_a = XW'(r_a);
        w_b = XW'(r_b);
        w_r = XW'($signed({1'b0, r_rad}));
        if (w_d >= (w_a <<< 1)) begin
            upd_d = DW'(w_d - (w_a <<< 1) - ONE_X);
            upd_a = r_a + ONE_C;
            upd_b = r_b;
        end else if (w_d < ((w_r - w_b) <<< 1)) begin
            upd_d = DW'(w_d + (w_b <<< 1) - ONE_X);
            upd_a = r_a;
            upd_b = r_b - ONE_C;
        end else begin
            upd_d = DW'(w_d + ((w_b - w_a - ONE_X) <<< 1));
            upd_a = r_a + ONE_C;
            upd_b = r_b - ONE_C;
        end
        upd_done = (upd_b < upd_a);
    end

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rad    = r_rad;
        n_a      = r_a;
        n_b      = r_b;
        n_d      = r_d;
        n_active = r_active;
        n_fill   = r_fill;
        if (in_acc && (s_axis_tuser == ACT_START)) begin
            n_cx     = s_axis_tdata[CW-1:0];
            n_cy     = s_axis_tdata[2*CW-1:CW];
            n_rad    = s_axis_tdata[3*CW-2:2*CW];
            n_fill   = s_axis_tdata[3*CW-1];
            n_a      = '0;
            n_b      = $signed({1'b0, s_axis_tdata[3*CW-2:2*CW]});
            n_d      = DW'($signed({1'b0, s_axis_tdata[3*CW-2:2*CW]})) - ONE_D;
            n_active = 1'b1;
        end else if (step_run) begin
            n_a      = upd_a;
            n_b      = upd_b;
            n_d      = upd_d;
            n_active = !upd_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_rad    <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_d      <= '0;
            r_active <= 1'b0;
            r_fill   <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_rad    <= n_rad;
            r_a      <= n_a;
            r_b      <= n_b;
            r_d      <= n_d;
            r_active <= n_active;
            r_fill   <= n_fill;
        end
    end

    // emitter holds the offsets of the step being sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (step_run) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && out_load) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_run) begin
            r_e_cx   <= r_cx;
            r_e_cy   <= r_cy;
            r_e_a    <= r_a;
            r_e_b    <= r_b;
            r_e_fill <= r_fill;
            r_e_done <= upd_done;
        end
    end

    assign w_sel.fill = r_e_fill;
    assign w_sel.idx  = r_idx;

    cpsg_span #(
        .COORD_BITS (COORD_BITS)
    ) u_span (
        .i_cx   (r_e_cx),
        .i_cy   (r_e_cy),
        .i_a    (r_e_a),
        .i_b    (r_e_b),
        .i_sel  (w_sel),
        .o_xs   (w_xs),
        .o_xe   (w_xe),
        .o_y    (w_y),
        .o_last (w_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= OUT_W'({w_y, w_xe, w_xs});
            r_m_last <= w_last;
            r_m_done <= w_last && r_e_done;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_done;

    a_done_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("circle done without end of step");

    a_ready_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_busy)
        else $error("input stalled while emitter free");

    a_fill_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_e_fill) |-> !r_idx[SEQ_W-1])
        else $error("fill step past its fourth span");

    a_step_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_run |=> (r_busy && (r_idx == '0)))
        else $error("running step did not start emitter");

endmodule

FILE: hw/rtl/cpsg_span.sv
// ----------------------------------------------------------------------------
// cpsg_span
// selects one symmetric point or span of the current iteration
// ----------------------------------------------------------------------------
module cpsg_span
    import cpsg_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  t_span_sel                    i_sel,
    output logic signed [COORD_BITS:0]   o_xs,
    output logic signed [COORD_BITS:0]   o_xe,
    output logic signed [COORD_BITS:0]   o_y,
    output logic                         o_last
);

    localparam int EW = COORD_BITS + 1;

    logic signed [EW-1:0] w_cx, w_cy, w_a, w_b;
    logic signed [EW-1:0] w_off_x, w_off_y;

    assign w_cx = EW'(i_cx);
    assign w_cy = EW'(i_cy);
    assign w_a  = EW'(i_a);
    assign w_b  = EW'(i_b);

    always_comb begin
        if (i_sel.fill) begin
            // outer rows use half width a, inner rows half width b
            w_off_x = (i_sel.idx[0] == i_sel.idx[1]) ? w_b : w_a;
            w_off_y = (i_sel.idx[0] == i_sel.idx[1]) ? w_a : w_b;
            o_xs    = w_cx - w_off_x;
            o_xe    = w_cx + w_off_x;
            o_y     = i_sel.idx[1] ? (w_cy - w_off_y) : (w_cy + w_off_y);
        end else begin
            w_off_x = i_sel.idx[0] ? w_b : w_a;
            w_off_y = i_sel.idx[0] ? w_a : w_b;
            o_xs    = i_sel.idx[1] ? (w_cx - w_off_x) : (w_cx + w_off_x);
            o_xe    = o_xs;
            o_y     = i_sel.idx[2] ? (w_cy - w_off_y) : (w_cy + w_off_y);
        end
        o_last = (i_sel.idx == (i_sel.fill ? FILL_LAST : OUTLINE_LAST));
    end

endmodule
